// ----- rtl/scc_pkg.sv -----
package scc_pkg;

    typedef enum logic [1:0] {
        CMD_POINT  = 2'd0,
        CMD_SPHERE = 2'd1,
        CMD_BOX    = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        CONT_NONE      = 2'd0,
        CONT_INTERSECT = 2'd1,
        CONT_CONTAINS  = 2'd2
    } t_cont;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_Z = 2'd2;
    localparam logic [1:0] REG_RADIUS   = 2'd3;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int OUT_TDATA_W = 8;

endpackage

// ----- rtl/sphere_containment_classifier_unit.sv -----
// Classifies one streamed primitive (point, sphere or axis-aligned box) against the
// query sphere held in the APB registers and returns none, intersects or contains.
// One transaction is accepted every cycle unless an output stall has filled the pipeline;
// each result passes through the input register, per-axis distances, squares, sums,
// compare and result register, and the five-deep pipeline absorbs output stalls stage
// by stage. Squared distances are exact, so no rounding or overflow occurs. Write the
// registers only while no transaction is in flight.
module sphere_containment_classifier_unit
    import scc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, other_radius, zero pad
    input  logic [((7*COORD_WIDTH+6)/8)*8-1:0] s_axis_tdata,
    // command
    input  logic [1:0]               s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // containment, zero pad
    output logic [OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready
);

    localparam int W     = COORD_WIDTH;
    localparam int SQ_W  = 2*W;
    localparam int SUM_W = 2*W + 2;

    logic signed [W-1:0] center [3];
    logic [W-2:0]        radius;

    scc_cfg_regs #(.COORD_WIDTH(W)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_center_x (center[0]),
        .o_center_y (center[1]),
        .o_center_z (center[2]),
        .o_radius   (radius)
    );

    // pipeline flow control
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic en0, en1, en2, en3, en4;

    assign en4 = !r_v4 || m_axis_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;

    assign s_axis_tready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en0) r_v0 <= s_axis_tvalid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // stage 0: input register
    logic [1:0]          r0_cmd;
    logic signed [W-1:0] r0_a [3];
    logic signed [W-1:0] r0_b [3];
    logic [W-2:0]        r0_ro;

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r0_cmd  <= s_axis_tuser;
            r0_a[0] <= signed'(s_axis_tdata[W-1:0]);
            r0_a[1] <= signed'(s_axis_tdata[2*W-1:W]);
            r0_a[2] <= signed'(s_axis_tdata[3*W-1:2*W]);
            r0_b[0] <= signed'(s_axis_tdata[4*W-1:3*W]);
            r0_b[1] <= signed'(s_axis_tdata[5*W-1:4*W]);
            r0_b[2] <= signed'(s_axis_tdata[6*W-1:5*W]);
            r0_ro   <= s_axis_tdata[7*W-2:6*W];
        end
    end

    // stage 1: per-axis distances and radius sum / difference
    logic [W-1:0] near_d [3];
    logic [W-1:0] far_d  [3];
    logic         is_box;

    assign is_box = (r0_cmd == CMD_BOX);

    for (genvar g = 0; g < 3; g++) begin : g_axis
        scc_axis_prep #(.COORD_WIDTH(W)) u_axis (
            .i_box    (is_box),
            .i_center (center[g]),
            .i_vec_a  (r0_a[g]),
            .i_vec_b  (r0_b[g]),
            .o_near   (near_d[g]),
            .o_far    (far_d[g])
        );
    end

    logic [1:0]   r1_cmd;
    logic [W-1:0] r1_near [3];
    logic [W-1:0] r1_far  [3];
    logic [W-2:0] r1_rq;
    logic [W-2:0] r1_rdiff;
    logic [W-1:0] r1_rsum;
    logic         r1_inner_ok;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_cmd      <= r0_cmd;
            r1_near     <= near_d;
            r1_far      <= far_d;
            r1_rq       <= radius;
            r1_rdiff    <= radius - r0_ro;
            r1_rsum     <= W'(radius) + W'(r0_ro);
            r1_inner_ok <= (r0_ro <= radius);
        end
    end

    // stage 2: squares
    logic [1:0]      r2_cmd;
    logic [SQ_W-1:0] r2_near_sq [3];
    logic [SQ_W-1:0] r2_far_sq  [3];
    logic [SQ_W-3:0] r2_rq_sq;
    logic [SQ_W-3:0] r2_rdiff_sq;
    logic [SQ_W-1:0] r2_rsum_sq;
    logic            r2_inner_ok;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_cmd      <= r1_cmd;
            for (int i = 0; i < 3; i++) begin
                r2_near_sq[i] <= r1_near[i] * r1_near[i];
                r2_far_sq[i]  <= r1_far[i] * r1_far[i];
            end
            r2_rq_sq    <= r1_rq * r1_rq;
            r2_rdiff_sq <= r1_rdiff * r1_rdiff;
            r2_rsum_sq  <= r1_rsum * r1_rsum;
            r2_inner_ok <= r1_inner_ok;
        end
    end

    // stage 3: sums of squares
    logic [1:0]       r3_cmd;
    logic [SUM_W-1:0] r3_near_sq;
    logic [SUM_W-1:0] r3_far_sq;
    logic [SQ_W-3:0]  r3_rq_sq;
    logic [SQ_W-3:0]  r3_rdiff_sq;
    logic [SQ_W-1:0]  r3_rsum_sq;
    logic             r3_inner_ok;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_cmd      <= r2_cmd;
            r3_near_sq  <= SUM_W'(r2_near_sq[0]) + SUM_W'(r2_near_sq[1])
                         + SUM_W'(r2_near_sq[2]);
            r3_far_sq   <= SUM_W'(r2_far_sq[0]) + SUM_W'(r2_far_sq[1])
                         + SUM_W'(r2_far_sq[2]);
            r3_rq_sq    <= r2_rq_sq;
            r3_rdiff_sq <= r2_rdiff_sq;
            r3_rsum_sq  <= r2_rsum_sq;
            r3_inner_ok <= r2_inner_ok;
        end
    end

    // stage 4: compare and result register
    t_cont n_cont;
    t_cont r4_cont;

    scc_classify #(.COORD_WIDTH(W)) u_classify (
        .i_cmd      (r3_cmd),
        .i_inner_ok (r3_inner_ok),
        .i_near_sq  (r3_near_sq),
        .i_far_sq   (r3_far_sq),
        .i_rq_sq    (r3_rq_sq),
        .i_rdiff_sq (r3_rdiff_sq),
        .i_rsum_sq  (r3_rsum_sq),
        .o_cont     (n_cont)
    );

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_cont <= n_cont;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {{(OUT_TDATA_W-2){1'b0}}, r4_cont};

endmodule

// ----- rtl/scc_cfg_regs.sv -----
module scc_cfg_regs
    import scc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,
    output logic signed [COORD_WIDTH-1:0] o_center_x,
    output logic signed [COORD_WIDTH-1:0] o_center_y,
    output logic signed [COORD_WIDTH-1:0] o_center_z,
    output logic [COORD_WIDTH-2:0]        o_radius
);

    logic [COORD_WIDTH-1:0] r_center_x;
    logic [COORD_WIDTH-1:0] r_center_y;
    logic [COORD_WIDTH-1:0] r_center_z;
    logic [COORD_WIDTH-2:0] r_radius;
    logic                   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= '0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_CENTER_X: r_center_x <= pwdata[COORD_WIDTH-1:0];
                REG_CENTER_Y: r_center_y <= pwdata[COORD_WIDTH-1:0];
                REG_CENTER_Z: r_center_z <= pwdata[COORD_WIDTH-1:0];
                REG_RADIUS:   r_radius   <= pwdata[COORD_WIDTH-2:0];
                default:      r_radius   <= r_radius;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CENTER_X: prdata = APB_DATA_W'(r_center_x);
            REG_CENTER_Y: prdata = APB_DATA_W'(r_center_y);
            REG_CENTER_Z: prdata = APB_DATA_W'(r_center_z);
            REG_RADIUS:   prdata = APB_DATA_W'(r_radius);
            default:      prdata = '0;
        endcase
    end

    assign o_center_x = signed'(r_center_x);
    assign o_center_y = signed'(r_center_y);
    assign o_center_z = signed'(r_center_z);
    assign o_radius   = r_radius;

endmodule

// ----- rtl/scc_axis_prep.sv -----
module scc_axis_prep
    import scc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_box,
    input  logic signed [COORD_WIDTH-1:0] i_center,
    input  logic signed [COORD_WIDTH-1:0] i_vec_a,
    input  logic signed [COORD_WIDTH-1:0] i_vec_b,
    output logic [COORD_WIDTH-1:0]        o_near,
    output logic [COORD_WIDTH-1:0]        o_far
);

    logic signed [COORD_WIDTH:0] diff_a;
    logic signed [COORD_WIDTH:0] diff_b;
    logic [COORD_WIDTH:0]        abs_a;
    logic [COORD_WIDTH:0]        abs_b;
    logic [COORD_WIDTH-1:0]      dist_a;
    logic [COORD_WIDTH-1:0]      dist_b;

    assign diff_a = (COORD_WIDTH+1)'(i_center) - (COORD_WIDTH+1)'(i_vec_a);
    assign diff_b = (COORD_WIDTH+1)'(i_center) - (COORD_WIDTH+1)'(i_vec_b);
    assign abs_a  = diff_a[COORD_WIDTH] ? unsigned'(-diff_a) : unsigned'(diff_a);
    assign abs_b  = diff_b[COORD_WIDTH] ? unsigned'(-diff_b) : unsigned'(diff_b);
    assign dist_a = abs_a[COORD_WIDTH-1:0];
    assign dist_b = abs_b[COORD_WIDTH-1:0];

    // box: clamp the center into [min, max], min tested first
    always_comb begin
        if (!i_box) begin
            o_near = dist_a;
        end else if (diff_a[COORD_WIDTH]) begin
            o_near = dist_a;
        end else if (!diff_b[COORD_WIDTH] && (diff_b != '0)) begin
            o_near = dist_b;
        end else begin
            o_near = '0;
        end
    end

    assign o_far = (dist_a > dist_b) ? dist_a : dist_b;

endmodule

// ----- rtl/scc_classify.sv -----
module scc_classify
    import scc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic [1:0]               i_cmd,
    input  logic                     i_inner_ok,
    input  logic [2*COORD_WIDTH+1:0] i_near_sq,
    input  logic [2*COORD_WIDTH+1:0] i_far_sq,
    input  logic [2*COORD_WIDTH-3:0] i_rq_sq,
    input  logic [2*COORD_WIDTH-3:0] i_rdiff_sq,
    input  logic [2*COORD_WIDTH-1:0] i_rsum_sq,
    output t_cont                    o_cont
);

    localparam int SUM_W = 2*COORD_WIDTH + 2;

    logic near_in_rq;
    logic far_in_rq;
    logic near_in_rdiff;
    logic near_in_rsum;

    assign near_in_rq    = i_near_sq <= SUM_W'(i_rq_sq);
    assign far_in_rq     = i_far_sq  <= SUM_W'(i_rq_sq);
    assign near_in_rdiff = i_near_sq <= SUM_W'(i_rdiff_sq);
    assign near_in_rsum  = i_near_sq <= SUM_W'(i_rsum_sq);

    always_comb begin
        case (i_cmd)
            CMD_POINT: begin
                o_cont = near_in_rq ? CONT_CONTAINS : CONT_NONE;
            end
            CMD_SPHERE: begin
                if (i_inner_ok && near_in_rdiff) begin
                    o_cont = CONT_CONTAINS;
                end else if (near_in_rsum) begin
                    o_cont = CONT_INTERSECT;
                end else begin
                    o_cont = CONT_NONE;
                end
            end
            CMD_BOX: begin
                if (!near_in_rq) begin
                    o_cont = CONT_NONE;
                end else if (far_in_rq) begin
                    o_cont = CONT_CONTAINS;
                end else begin
                    o_cont = CONT_INTERSECT;
                end
            end
            default: o_cont = CONT_NONE;
        endcase
    end

endmodule

// ----- dv/sphere_containment_classifier_unit_tb.sv -----
module sphere_containment_classifier_unit_tb;
    import scc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = 24;
    localparam int TDATA_W   = ((7*CW+6)/8)*8;
    localparam int CYCLE_CAP = 400000;
    localparam longint C_MAX = 8388607;
    localparam longint C_MIN = -8388608;
    localparam longint R_MAX = 8388607;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [CW-2:0]        oradius;
        logic [2:0][CW-1:0]   corner_b;
        logic [2:0][CW-1:0]   corner_a;
    } t_prim;

    class containment_scoreboard;
        logic signed [CW-1:0] center [3];
        logic [CW-2:0]        radius;
        t_cont                expected_cont[$];
        int                   mismatches;
        int                   kind_count [4];
        int                   cont_count [3];

        function new();
            for (int i = 0; i < 3; i++) begin
                center[i] = '0;
            end
            radius     = '0;
            mismatches = 0;
            for (int i = 0; i < 4; i++) begin
                kind_count[i] = 0;
            end
            for (int i = 0; i < 3; i++) begin
                cont_count[i] = 0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == REG_RADIUS) begin
                radius = val[CW-2:0];
            end else begin
                center[idx] = val[CW-1:0];
            end
        endfunction

        function t_cont classify(t_prim p);
            longint c, a, b, q, da2, db2, dist2, near2, far2, rq, ro;
            dist2 = 0;
            near2 = 0;
            far2  = 0;
            rq    = longint'(radius);
            ro    = longint'(p.oradius);
            for (int i = 0; i < 3; i++) begin
                c = center[i];
                a = $signed(p.corner_a[i]);
                b = $signed(p.corner_b[i]);
                da2 = (c - a) * (c - a);
                db2 = (c - b) * (c - b);
                dist2 += da2;
                far2  += (da2 > db2) ? da2 : db2;
                q = c;
                if (c < a) begin
                    q = a;
                end else if (c > b) begin
                    q = b;
                end
                near2 += (c - q) * (c - q);
            end
            case (p.cmd)
                CMD_POINT:  return (dist2 <= rq * rq) ? CONT_CONTAINS : CONT_NONE;
                CMD_SPHERE: begin
                    if (ro <= rq && dist2 <= (rq - ro) * (rq - ro))
                        return CONT_CONTAINS;
                    if (dist2 <= (rq + ro) * (rq + ro))
                        return CONT_INTERSECT;
                    return CONT_NONE;
                end
                CMD_BOX: begin
                    if (near2 > rq * rq)
                        return CONT_NONE;
                    return (far2 <= rq * rq) ? CONT_CONTAINS : CONT_INTERSECT;
                end
                default: return CONT_NONE;
            endcase
        endfunction

        function void note_primitive(t_prim p);
            kind_count[p.cmd]++;
            expected_cont.push_back(classify(p));
        endfunction

        function void report(string what, logic [1:0] exp_v, logic [1:0] act_v);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] containment mismatch (%s): expected %0d, got %0d",
                         $time, what, exp_v, act_v);
            end
        endfunction

        function void check_containment(logic [OUT_TDATA_W-1:0] data);
            t_cont exp_c;
            if (expected_cont.size() == 0) begin
                report("no transaction pending", 2'bxx, data[1:0]);
            end else begin
                exp_c = expected_cont.pop_front();
                if (data[1:0] !== exp_c) begin
                    report("result field", exp_c, data[1:0]);
                end
                if (exp_c <= CONT_CONTAINS) begin
                    cont_count[exp_c]++;
                end
            end
        endfunction

        function int pending();
            return expected_cont.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TDATA_W-1:0]     s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    containment_scoreboard sb;
    bit     tx_gaps_on;
    bit     rx_stall_on;
    int     stall_left;
    int     cycles;
    int     settings;

    sphere_containment_classifier_unit #(
        .COORD_WIDTH(CW)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int idle_cycles();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [CW-1:0] clamp_coord(longint v);
        if (v > C_MAX)
            v = C_MAX;
        if (v < C_MIN)
            v = C_MIN;
        return v[CW-1:0];
    endfunction

    function automatic t_prim mk(logic [1:0] cmd, longint ax, longint ay, longint az,
                                 longint bx, longint by, longint bz, longint ro);
        t_prim p;
        p.cmd         = cmd;
        p.corner_a[0] = clamp_coord(ax);
        p.corner_a[1] = clamp_coord(ay);
        p.corner_a[2] = clamp_coord(az);
        p.corner_b[0] = clamp_coord(bx);
        p.corner_b[1] = clamp_coord(by);
        p.corner_b[2] = clamp_coord(bz);
        p.oradius     = (ro > R_MAX) ? R_MAX[CW-2:0] : ro[CW-2:0];
        return p;
    endfunction

    function automatic logic [CW-1:0] rand_coord(int axis, longint span);
        longint ofs;
        if ($urandom_range(0, 9) < 2)
            return CW'($urandom());
        ofs = longint'($urandom_range(0, int'(2 * span))) - span;
        return clamp_coord(longint'(sb.center[axis]) + ofs);
    endfunction

    function automatic t_prim random_prim();
        t_prim  p;
        int     r;
        longint rq, ro, span;
        logic [CW-1:0] tmp;
        rq = longint'(sb.radius);
        r  = $urandom_range(0, 19);
        p.cmd = (r == 0) ? 2'd3 : 2'(r % 3);
        if ($urandom_range(0, 4) == 0)
            ro = $urandom() & R_MAX;
        else
            ro = $urandom_range(0, int'(rq + rq / 2 + 4));
        if (ro > R_MAX)
            ro = R_MAX;
        p.oradius = ro[CW-2:0];
        case ($urandom_range(0, 2))
            0: span = rq / 2 + 2;
            1: span = rq + rq / 4 + 4;
            default: span = rq + ro + 4;
        endcase
        for (int i = 0; i < 3; i++) begin
            p.corner_a[i] = rand_coord(i, span);
            p.corner_b[i] = rand_coord(i, span);
            if ($urandom_range(0, 7) != 0 &&
                $signed(p.corner_a[i]) > $signed(p.corner_b[i])) begin
                tmp           = p.corner_a[i];
                p.corner_a[i] = p.corner_b[i];
                p.corner_b[i] = tmp;
            end
        end
        return p;
    endfunction

    always @(posedge i_clk) begin
        if (!rx_stall_on) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= idle_cycles() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_primitive({s_axis_tuser, s_axis_tdata[TDATA_W-2:0]});
            if (m_axis_tvalid && m_axis_tready)
                sb.check_containment(m_axis_tdata);
        end
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_prim(t_prim p);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? idle_cycles() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, p.oradius, p.corner_b, p.corner_a};
        s_axis_tuser  <= p.cmd;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, longint val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val[31:0];
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val[31:0]);
        @(posedge i_clk);
    endtask

    task automatic set_query(longint cx, longint cy, longint cz, longint r);
        apb_write(REG_CENTER_X, cx);
        apb_write(REG_CENTER_Y, cy);
        apb_write(REG_CENTER_Z, cz);
        apb_write(REG_RADIUS, r);
        settings++;
    endtask

    function automatic longint random_center();
        int k;
        if ($urandom_range(0, 3) == 0)
            return $signed(CW'($urandom()));
        k = $urandom_range(0, 22);
        return longint'($urandom_range(0, 2 * (32'd1 << k))) - (longint'(1) << k);
    endfunction

    initial begin
        longint cx, cy, cz, r;
        sb            = new();
        cycles        = 0;
        settings      = 1;
        stall_left    = 0;
        tx_gaps_on    = 1'b0;
        rx_stall_on   = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b1;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: zero radius at the origin
        send_prim(mk(CMD_POINT, 0, 0, 0, 0, 0, 0, 0));
        send_prim(mk(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0));
        send_prim(mk(CMD_BOX, 0, 0, 0, 0, 0, 0, 0));
        send_prim(mk(2'd3, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        set_query(100, -200, 300, 1000);
        send_prim(mk(CMD_POINT, 100, -200, 300, 0, 0, 0, 0));
        send_prim(mk(CMD_POINT, 1100, -200, 300, 0, 0, 0, 0));
        send_prim(mk(CMD_POINT, 1101, -200, 300, 0, 0, 0, 0));
        send_prim(mk(CMD_SPHERE, 100, -200, 300, 0, 0, 0, 0));
        send_prim(mk(CMD_SPHERE, 100, -200, 300, 0, 0, 0, 1000));
        send_prim(mk(CMD_SPHERE, 100, -200, 300, 0, 0, 0, 1001));
        send_prim(mk(CMD_SPHERE, 700, -200, 300, 0, 0, 0, 400));
        send_prim(mk(CMD_SPHERE, 701, -200, 300, 0, 0, 0, 400));
        send_prim(mk(CMD_SPHERE, 1500, -200, 300, 0, 0, 0, 400));
        send_prim(mk(CMD_SPHERE, 1501, -200, 300, 0, 0, 0, 400));
        send_prim(mk(CMD_BOX, 90, -210, 290, 110, -190, 310, 0));
        send_prim(mk(CMD_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0));
        send_prim(mk(CMD_BOX, 1100, -500, 0, 2000, 100, 600, 0));
        send_prim(mk(CMD_BOX, 1101, -500, 0, 2000, 100, 600, 0));
        send_prim(mk(CMD_BOX, 100, -200, 300, 100, -200, 300, 0));
        // inverted box: min above max on every axis
        send_prim(mk(CMD_BOX, 150, -150, 350, 50, -250, 250, 0));
        send_prim(mk(CMD_BOX, 100, -200, 300, 700, 600, 300, 0));
        send_prim(mk(2'd3, 100, -200, 300, 100, -200, 300, 5));
        wait_drained();

        set_query(C_MIN, C_MIN, C_MIN, R_MAX);
        send_prim(mk(CMD_POINT, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0));
        send_prim(mk(CMD_POINT, -1, C_MIN, C_MIN, 0, 0, 0, 0));
        send_prim(mk(CMD_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, R_MAX));
        send_prim(mk(CMD_SPHERE, C_MIN, C_MIN, C_MIN, 0, 0, 0, R_MAX));

        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                0: set_query(C_MAX, C_MAX, C_MAX, 0);
                1: set_query(C_MIN, C_MAX, C_MIN, R_MAX);
                default: begin
                    cx = random_center();
                    cy = random_center();
                    cz = random_center();
                    r  = longint'($urandom_range(0, (32'd1 << $urandom_range(0, 23)) - 1));
                    set_query(cx, cy, cz, r);
                end
            endcase
            tx_gaps_on  <= (ph != 2);
            rx_stall_on <= (ph != 2) && (ph != 4);
            for (int n = 0; n < 85; n++) begin
                if (ph == 3 && n == 40)
                    wait_drained();
                send_prim(random_prim());
            end
        end
        wait_drained();

        if (sb.pending() != 0)
            sb.mismatches++;
        $display("Checked %0d points, %0d spheres, %0d boxes, %0d unused kinds over %0d settings",
                 sb.kind_count[0], sb.kind_count[1], sb.kind_count[2], sb.kind_count[3],
                 settings);
        $display("Expected none/intersects/contains: %0d/%0d/%0d, failures: %0d",
                 sb.cont_count[0], sb.cont_count[1], sb.cont_count[2], sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sphere_containment_classifier_unit.f -----
rtl/scc_pkg.sv
rtl/scc_cfg_regs.sv
rtl/scc_axis_prep.sv
rtl/scc_classify.sv
rtl/sphere_containment_classifier_unit.sv
dv/sphere_containment_classifier_unit_tb.sv
